// ===== rtl/slcan_pkg.sv =====
package slcan_pkg;

    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_T_STD  = 8'h74;
    localparam logic [7:0] CH_T_EXT  = 8'h54;
    localparam logic [7:0] CH_R_STD  = 8'h72;
    localparam logic [7:0] CH_R_EXT  = 8'h52;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [3:0] HEX_TEN   = 4'd10;
    localparam logic [3:0] MAX_DLC   = 4'd8;
    localparam logic [3:0] ID_STD_DIGITS = 4'd3;
    localparam logic [3:0] ID_EXT_DIGITS = 4'd8;

    // character class handed from the front part to the decoder
    typedef enum logic [3:0] {
        CLS_LETTER = 4'b0001,
        CLS_HEX    = 4'b0010,
        CLS_CR     = 4'b0100,
        CLS_OTHER  = 4'b1000
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  nibble;
        logic        ext;
        logic        rtr;
    } char_tok_t;

    typedef struct packed {
        logic [28:0] can_id;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  data_length;
        logic [63:0] payload;
        logic [15:0] time_stamp;
    } can_frame_t;

endpackage

// ===== rtl/slcan_if.sv =====
interface slcan_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcan_frame_if;
    logic        valid;
    logic        ready;
    logic [28:0] can_id;
    logic        is_extended;
    logic        is_remote;
    logic [3:0]  data_length;
    logic [63:0] payload;
    logic [15:0] time_stamp;
    modport source (output valid, output can_id, output is_extended, output is_remote,
                    output data_length, output payload, output time_stamp, input ready);
    modport sink (input valid, input can_id, input is_extended, input is_remote,
                  input data_length, input payload, input time_stamp, output ready);
endinterface

// ===== rtl/slcan_classify.sv =====
module slcan_classify
    import slcan_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       tok_valid,
    input  logic       tok_ready,
    output char_tok_t  tok
);

    char_tok_t tok_d;
    logic      tok_valid_reg;
    char_tok_t tok_reg;

    // decode one character
    always_comb
    begin
        tok_d.nibble = 4'd0;
        tok_d.ext    = (in_byte == CH_T_EXT) || (in_byte == CH_R_EXT);
        tok_d.rtr    = (in_byte == CH_R_STD) || (in_byte == CH_R_EXT);
        if (in_byte >= CH_ZERO && in_byte <= CH_NINE)
        begin
            tok_d.cls    = CLS_HEX;
            tok_d.nibble = 4'(in_byte - CH_ZERO);
        end
        else if (in_byte >= CH_UA && in_byte <= CH_UF)
        begin
            tok_d.cls    = CLS_HEX;
            tok_d.nibble = 4'(in_byte - CH_UA) + HEX_TEN;
        end
        else if (in_byte >= CH_LA && in_byte <= CH_LF)
        begin
            tok_d.cls    = CLS_HEX;
            tok_d.nibble = 4'(in_byte - CH_LA) + HEX_TEN;
        end
        else if (in_byte == CH_CR)
            tok_d.cls = CLS_CR;
        else if (in_byte == CH_T_STD || in_byte == CH_T_EXT ||
                 in_byte == CH_R_STD || in_byte == CH_R_EXT)
            tok_d.cls = CLS_LETTER;
        else
            tok_d.cls = CLS_OTHER;
    end

    assign in_ready  = !tok_valid_reg || tok_ready;
    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

    // single token register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else if (in_ready)
            tok_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            tok_reg <= tok_d;
    end

endmodule

// ===== rtl/slcan_decode.sv =====
module slcan_decode
    import slcan_pkg::*;
#(
    parameter int MAX_LINE_BYTES = 80
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tok_valid,
    output logic       tok_ready,
    input  char_tok_t  tok,
    output logic       frm_valid,
    input  logic       frm_ready,
    output can_frame_t frm
);

    logic        in_frame_reg, in_frame_next;
    logic [6:0]  pos_reg, pos_next;
    logic        ext_reg, ext_next, rtr_reg, rtr_next;
    logic        bad_reg, bad_next;
    logic [28:0] id_reg, id_next;
    logic [3:0]  len_reg, len_next;
    logic [63:0] pay_reg, pay_next;
    logic [15:0] stamp_reg, stamp_next;
    logic [2:0]  sd_reg, sd_next;
    logic        frm_valid_reg;
    can_frame_t  frm_reg, frm_d;
    logic        emit;
    logic        take;

    logic [3:0]  id_digits;
    logic [4:0]  data_digits;
    logic [6:0]  p1;
    logic [6:0]  j;
    logic [5:0]  sh;
    logic [7:0]  total;

    assign tok_ready = !frm_valid_reg || frm_ready;
    assign take      = tok_valid && tok_ready;
    assign id_digits = ext_reg ? ID_EXT_DIGITS : ID_STD_DIGITS;
    assign data_digits = rtr_reg ? 5'd0 : {len_reg, 1'b0};
    assign p1    = pos_reg + 7'd1;
    assign j     = p1 - 7'(id_digits) - 7'd2;
    assign sh    = {j[3:1], 3'b000} + (j[0] ? 6'd0 : 6'd4);
    assign total = 8'(id_digits) + 8'd1 + 8'(data_digits) + 8'(sd_reg);

    // per-character line decoder
    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next   = pos_reg;
        ext_next   = ext_reg;
        rtr_next   = rtr_reg;
        bad_next   = bad_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        pay_next   = pay_reg;
        stamp_next = stamp_reg;
        sd_next    = sd_reg;
        emit       = 1'b0;
        frm_d.can_id      = id_reg;
        frm_d.is_extended = ext_reg;
        frm_d.is_remote   = rtr_reg;
        frm_d.data_length = len_reg;
        frm_d.payload     = rtr_reg ? 64'd0 : pay_reg;
        frm_d.time_stamp  = stamp_reg;
        if (!in_frame_reg)
        begin
            if (tok.cls == CLS_LETTER)
            begin
                in_frame_next = 1'b1;
                pos_next = '0; bad_next = 1'b0; id_next = '0; len_next = '0;
                pay_next = '0; stamp_next = '0; sd_next = '0;
                ext_next = tok.ext; rtr_next = tok.rtr;
            end
        end
        else if ({1'b0, pos_reg} + 8'd2 > 8'(MAX_LINE_BYTES))
            in_frame_next = 1'b0;
        else if (tok.cls == CLS_CR)
        begin
            in_frame_next = 1'b0;
            emit = !bad_reg && ({1'b0, pos_reg} >= 8'(id_digits) + 8'd1) &&
                   (sd_reg == 3'd0 || sd_reg == 3'd4) && ({1'b0, pos_reg} == total);
        end
        else
        begin
            pos_next = p1;
            if (tok.cls != CLS_HEX)
                bad_next = 1'b1;
            else if (!bad_reg)
            begin
                if (p1 <= 7'(id_digits))
                begin
                    if (p1 == 7'd1 && ((ext_reg && tok.nibble > 4'd1) ||
                                       (!ext_reg && tok.nibble > 4'd7)))
                        bad_next = 1'b1;
                    else
                        id_next = {id_reg[24:0], tok.nibble};
                end
                else if (p1 == 7'(id_digits) + 7'd1)
                begin
                    if (tok.nibble > MAX_DLC)
                        bad_next = 1'b1;
                    else
                        len_next = tok.nibble;
                end
                else if (j < 7'(data_digits))
                    pay_next = pay_reg | (64'(tok.nibble) << sh);
                else if (sd_reg < 3'd4)
                begin
                    stamp_next = {stamp_reg[11:0], tok.nibble};
                    sd_next    = sd_reg + 3'd1;
                end
                else
                    bad_next = 1'b1;
            end
        end
    end

    // line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg <= '0; ext_reg <= 1'b0; rtr_reg <= 1'b0; bad_reg <= 1'b0;
            id_reg <= '0; len_reg <= '0; pay_reg <= '0; stamp_reg <= '0; sd_reg <= '0;
        end
        else if (take)
        begin
            in_frame_reg <= in_frame_next;
            pos_reg <= pos_next; ext_reg <= ext_next; rtr_reg <= rtr_next;
            bad_reg <= bad_next; id_reg <= id_next; len_reg <= len_next;
            pay_reg <= pay_next; stamp_reg <= stamp_next; sd_reg <= sd_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frm_valid_reg <= 1'b0;
        else if (tok_ready)
            frm_valid_reg <= take && emit;
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
            frm_reg <= frm_d;
    end

    assign frm_valid = frm_valid_reg;
    assign frm       = frm_reg;

endmodule

// ===== rtl/slcan_frame_parser.sv =====
// Decodes serial-line CAN text (t/T/r/R lines ended by a carriage return) one byte
// per cycle while the frame output is not stalled. A classifier stage maps each
// byte to a token in a token register; a decoder stage builds the frame and holds
// it in an output register, so a frame passes both registers. Malformed or overlong lines
// (over MAX_LINE_BYTES) are dropped silently.
module slcan_frame_parser
    import slcan_pkg::*;
#(
    parameter int MAX_LINE_BYTES = 80
)
(
    input  logic    clk,
    input  logic    rst_n,
    slcan_byte_if.sink    rx,
    slcan_frame_if.source frame
);

    logic       tok_valid;
    logic       tok_ready;
    char_tok_t  tok;
    can_frame_t frm;

    slcan_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .in_byte   (rx.rx_byte),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok)
    );

    slcan_decode #(.MAX_LINE_BYTES(MAX_LINE_BYTES)) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok       (tok),
        .frm_valid (frame.valid),
        .frm_ready (frame.ready),
        .frm       (frm)
    );

    assign frame.can_id      = frm.can_id;
    assign frame.is_extended = frm.is_extended;
    assign frame.is_remote   = frm.is_remote;
    assign frame.data_length = frm.data_length;
    assign frame.payload     = frm.payload;
    assign frame.time_stamp  = frm.time_stamp;

endmodule

// ===== rtl/slcan_checker.sv =====
module slcan_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rx_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_ext,
    input logic [28:0] out_id,
    input logic [3:0]  out_len
);

    // a held frame stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("frame dropped while stalled");

    // standard identifiers fit in 11 bits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ext |-> out_id[28:11] == 18'd0)
        else $error("standard id too wide");

    // length never above eight
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_len <= 4'd8)
        else $error("bad length");

    // input is never blocked while the output is free
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |=> rx_ready || out_valid)
        else $error("input stalled without cause");

endmodule

bind slcan_frame_parser slcan_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_ready  (rx.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_ext   (frame.is_extended),
    .out_id    (frame.can_id),
    .out_len   (frame.data_length)
);

// ===== test/slcan_frame_parser_tb.sv =====
`timescale 1ns / 1ps

module slcan_frame_parser_tb;
    import slcan_pkg::*;

    localparam int LINE_LIMIT = 80;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;

    slcan_byte_if  rx_ch ();
    slcan_frame_if fr_ch ();

    slcan_frame_parser #(.MAX_LINE_BYTES(LINE_LIMIT)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch.sink),
        .frame (fr_ch.source)
    );

    // decoder state mirrored in the testbench
    logic        dec_busy;
    logic [6:0]  dec_pos;
    logic        dec_ext;
    logic        dec_rtr;
    logic        dec_bad;
    logic [28:0] dec_id;
    logic [3:0]  dec_len;
    logic [63:0] dec_data;
    logic [15:0] dec_stamp;
    logic [2:0]  dec_stamp_cnt;

    logic [7:0]  byte_queue[$];
    can_frame_t  frame_queue[$];
    int          n_fail;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          quiet_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report(input string what);
        $display("mismatch: %s", what);
        n_fail++;
    endtask

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    task automatic clear_line();
        dec_busy = 0; dec_pos = 0; dec_ext = 0; dec_rtr = 0; dec_bad = 0;
        dec_id = 0; dec_len = 0; dec_data = 0; dec_stamp = 0; dec_stamp_cnt = 0;
    endtask

    // advance the decoder by one byte, queue a frame when a good line closes
    task automatic decode_byte(input logic [7:0] c);
        int nid;
        int ndata;
        int p;
        int v;
        int j;
        can_frame_t f;
        if (!dec_busy) begin
            if (c == CH_T_STD || c == CH_T_EXT || c == CH_R_STD || c == CH_R_EXT) begin
                clear_line();
                dec_busy = 1;
                dec_ext = (c == CH_T_EXT || c == CH_R_EXT);
                dec_rtr = (c == CH_R_STD || c == CH_R_EXT);
            end
            return;
        end
        if (int'(dec_pos) + 2 > LINE_LIMIT) begin
            clear_line();
            return;
        end
        nid = dec_ext ? 8 : 3;
        ndata = dec_rtr ? 0 : 2 * int'(dec_len);
        if (c == CH_CR) begin
            if (!dec_bad && int'(dec_pos) >= nid + 1
                && (dec_stamp_cnt == 0 || dec_stamp_cnt == 4)
                && int'(dec_pos) == nid + 1 + ndata + int'(dec_stamp_cnt)) begin
                f.can_id = dec_id;
                f.is_extended = dec_ext;
                f.is_remote = dec_rtr;
                f.data_length = dec_len;
                f.payload = dec_rtr ? 64'd0 : dec_data;
                f.time_stamp = dec_stamp;
                frame_queue.push_back(f);
            end
            clear_line();
            return;
        end
        dec_pos = dec_pos + 7'd1;
        p = int'(dec_pos);
        v = nibble_of(c);
        if (v < 0) begin
            dec_bad = 1;
            return;
        end
        if (dec_bad) return;
        if (p <= nid) begin
            if (p == 1 && ((dec_ext && v > 1) || (!dec_ext && v > 7))) dec_bad = 1;
            else dec_id = {dec_id[24:0], 4'(v)};
        end else if (p == nid + 1) begin
            if (v > 8) dec_bad = 1;
            else dec_len = 4'(v);
        end else begin
            j = p - nid - 2;
            if (j < ndata) dec_data |= 64'(v) << (8 * (j / 2) + ((j % 2) ? 0 : 4));
            else if (dec_stamp_cnt < 4) begin
                dec_stamp = {dec_stamp[11:0], 4'(v)};
                dec_stamp_cnt++;
            end else dec_bad = 1;
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return CH_ZERO + 8'(n);
        return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(n - 4'd10);
    endfunction

    // raw text, byte by byte
    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) byte_queue.push_back(8'(s[i]));
    endtask

    // one line: letter, identifier, length, data, optional stamp, return
    task automatic push_line(input logic [7:0] letter, input logic [28:0] id,
                             input int len, input logic [63:0] data,
                             input bit with_stamp, input logic [15:0] stamp);
        int nid;
        bit rtr;
        nid = (letter == CH_T_EXT || letter == CH_R_EXT) ? 8 : 3;
        rtr = (letter == CH_R_STD || letter == CH_R_EXT);
        byte_queue.push_back(letter);
        for (int i = nid - 1; i >= 0; i--) byte_queue.push_back(hex_char(id[4*i +: 4]));
        byte_queue.push_back(hex_char(4'(len)));
        if (!rtr)
            for (int i = 0; i < len && i < 8; i++) begin
                byte_queue.push_back(hex_char(data[8*i+4 +: 4]));
                byte_queue.push_back(hex_char(data[8*i +: 4]));
            end
        if (with_stamp)
            for (int i = 3; i >= 0; i--) byte_queue.push_back(hex_char(stamp[4*i +: 4]));
        byte_queue.push_back(CH_CR);
    endtask

    function automatic logic [7:0] any_letter();
        case ($urandom_range(0, 3))
            0: return CH_T_STD;
            1: return CH_T_EXT;
            2: return CH_R_STD;
            default: return CH_R_EXT;
        endcase
    endfunction

    // random line, mostly good, sometimes broken
    task automatic push_random_line();
        logic [7:0] letter;
        logic [28:0] id;
        int len;
        int mode;
        int at;
        letter = any_letter();
        id = 29'({$urandom(), $urandom()});
        if (letter == CH_T_STD || letter == CH_R_STD) id[28:11] = 0;
        len = $urandom_range(0, 8);
        mode = $urandom_range(0, 9);
        at = byte_queue.size();
        push_line(letter, id, len, {$urandom(), $urandom()}, $urandom_range(0, 1),
                  16'($urandom()));
        if (mode == 7) byte_queue[at + $urandom_range(1, 3)] = 8'($urandom());
        else if (mode == 8) void'(byte_queue.pop_back());
        else if (mode == 9) begin
            at = at + $urandom_range(1, byte_queue.size() - at - 1);
            byte_queue.insert(at, $urandom_range(0, 1) ? hex_char(4'($urandom()))
                                                       : 8'($urandom()));
        end
        if ($urandom_range(0, 7) == 0) byte_queue.push_back(8'($urandom()));
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rx_ch.valid <= 1'b0;
            rx_ch.rx_byte <= 8'd0;
        end else begin
            if (rx_ch.valid && rx_ch.ready) decode_byte(rx_ch.rx_byte);
            if (!(rx_ch.valid && !rx_ch.ready)) begin
                if (byte_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    rx_ch.valid <= 1'b1;
                    rx_ch.rx_byte <= byte_queue.pop_front();
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        can_frame_t want;
        if (!rst_n) begin
            fr_ch.ready <= 1'b0;
        end else begin
            if (fr_ch.valid && fr_ch.ready) begin
                if (frame_queue.size() == 0) report("frame with nothing expected");
                else begin
                    want = frame_queue.pop_front();
                    if (fr_ch.can_id !== want.can_id)
                        report($sformatf("can_id %h want %h", fr_ch.can_id, want.can_id));
                    if (fr_ch.is_extended !== want.is_extended) report("is_extended");
                    if (fr_ch.is_remote !== want.is_remote) report("is_remote");
                    if (fr_ch.data_length !== want.data_length)
                        report($sformatf("data_length %0d want %0d",
                                         fr_ch.data_length, want.data_length));
                    if (fr_ch.payload !== want.payload)
                        report($sformatf("payload %h want %h", fr_ch.payload, want.payload));
                    if (fr_ch.time_stamp !== want.time_stamp)
                        report($sformatf("time_stamp %h want %h",
                                         fr_ch.time_stamp, want.time_stamp));
                end
            end
            fr_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk) begin
        if ((rx_ch.valid && rx_ch.ready) || (fr_ch.valid && fr_ch.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int total;
        int before_len;
        n_fail = 0;
        quiet_cycles = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        clear_line();
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'd0;
        fr_ch.ready = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed lines
        push_line(CH_T_STD, 29'h000, 0, 0, 0, 0);
        push_line(CH_T_STD, 29'h7ff, 8, 64'hffff_ffff_ffff_ffff, 1, 16'hffff);
        push_line(CH_T_EXT, 29'h1fff_ffff, 8, 64'h0123_4567_89ab_cdef, 1, 16'h0000);
        push_line(CH_R_STD, 29'h123, 8, 0, 0, 0);
        push_line(CH_R_EXT, 29'h0000_0000, 3, 0, 1, 16'hbeef);
        // standard id with first digit above 7
        byte_queue.push_back(CH_T_STD);
        push_text("8000");
        byte_queue.push_back(CH_CR);
        // length digit above 8
        byte_queue.push_back(CH_T_STD);
        push_text("1239");
        byte_queue.push_back(CH_CR);
        // timestamp of three digits, then stray return while idle
        byte_queue.push_back(CH_T_STD);
        push_text("12300ab");
        byte_queue.push_back(CH_CR);
        byte_queue.push_back(CH_CR);
        // overlong line, then a stray letter that makes the following line malformed
        byte_queue.push_back(CH_T_EXT);
        repeat (90) byte_queue.push_back(8'h30);
        byte_queue.push_back(CH_T_STD);
        push_line(CH_T_STD, 29'h001, 1, 64'h5a, 0, 0);
        for (int i = 0; i < 8; i++) byte_queue.push_back(8'(1 << i));
        byte_queue.push_back(8'hff);

        // random phases with different back-pressure, counted in bytes
        total = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin sender_idle_pct = 81; receiver_stall_pct = 0; end
                2: begin sender_idle_pct = 0; receiver_stall_pct = 81; end
                3: begin sender_idle_pct = 26; receiver_stall_pct = 26; end
                default: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
            endcase
            while (total < 330 * (ph + 1)) begin
                before_len = byte_queue.size();
                push_random_line();
                total = total + byte_queue.size() - before_len;
            end
            while (byte_queue.size() > 0 || rx_ch.valid) @(posedge clk);
        end
        while (frame_queue.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_fail == 0 && frame_queue.size() == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
